// ----- rtl/core/morse_pattern_buzzer_sequencer_unit_defines.svh -----
// Shared assertion macros for the buzzer sequencer checkers.
`ifndef MORSE_PATTERN_BUZZER_SEQUENCER_UNIT_DEFINES_SVH
`define MORSE_PATTERN_BUZZER_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MPBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/mpbs_pkg.sv -----
`default_nettype none

package mpbs_pkg;

	localparam int N_PATTERNS = 9;
	localparam int ROM_LEN    = 32;
	localparam int DUR_W      = 5;
	localparam int TICK_W     = 11;
	localparam int STEP_W     = 5;
	localparam int ID_W       = 4;
	localparam int LIM_W      = 8;

	localparam logic [DUR_W-1:0] DIT   = 5'd5;
	localparam logic [DUR_W-1:0] DAH   = 5'd15;
	localparam logic [DUR_W-1:0] P     = 5'd5;
	localparam logic [DUR_W-1:0] P_L   = 5'd25;
	localparam logic [DUR_W-1:0] START = 5'd1;
	localparam logic [DUR_W-1:0] DUR_END = 5'd0;
	localparam logic [LIM_W-1:0] NO_INT  = 8'd255;

	localparam logic [DUR_W-1:0] ROM_SEQ [N_PATTERNS][ROM_LEN] = '{
		'{0: START, 1: DIT, 2: P, 3: DAH, 4: P, 5: DIT, 6: P_L, 7: DAH, 8: P_L, 9: DAH,
		  10: P, 11: DIT, 12: P, 13: DAH, 14: P, 15: DIT, 16: P, default: DUR_END},
		'{0: START, 1: DAH, 2: P, 3: DIT, 4: P, 5: DAH, 6: P_L, 7: DIT, 8: P_L, 9: DAH,
		  10: P, 11: DIT, 12: P, 13: DAH, 14: P, 15: DAH, 16: P, default: DUR_END},
		'{0: START, 1: DIT, 2: P, 3: DAH, 4: P, default: DUR_END},
		'{0: START, 1: DIT, 2: P, 3: DIT, 4: P, 5: DAH, 6: P, 7: DIT, 8: P,
		  default: DUR_END},
		'{0: START, 1: DAH, 2: P, 3: DAH, 4: P, 5: DAH, 6: P_L, 7: DAH, 8: P, 9: DIT,
		  10: P, 11: DAH, 12: P, default: DUR_END},
		'{0: START, 1: DAH, 2: P, 3: DIT, 4: P, 5: DIT, 6: P, 7: DIT, 8: P_L, 9: DAH,
		  10: P, default: DUR_END},
		'{0: START, 1: DIT, 2: P, 3: DAH, 4: P, 5: DAH, 6: P_L, 7: DIT, 8: P, 9: DIT,
		  10: P, 11: DAH, 12: P, 13: DIT, 14: P, default: DUR_END},
		'{0: START, 1: DIT, 2: P, default: DUR_END},
		'{0: START, 1: DAH, 2: P, default: DUR_END}
	};

	localparam logic [LIM_W-1:0] ROM_INT [N_PATTERNS] = '{
		NO_INT, NO_INT, 8'd2, NO_INT, NO_INT, NO_INT, NO_INT, NO_INT, NO_INT
	};

	typedef struct packed {
		logic            req_type;
		logic [ID_W-1:0] melody_id;
	} req_t;

	typedef struct packed {
		logic buzzer_level;
		logic busy_res;
		logic dropped;
	} rsp_t;

	typedef struct packed {
		logic              playing;
		logic [ID_W-1:0]   cur_pat;
		logic [STEP_W-1:0] step_idx;
		logic              next_level;
		logic              out_level;
		logic [TICK_W-1:0] ticks;
	} seq_state_t;

	typedef struct packed {
		logic            push;
		logic            pop;
		logic [ID_W-1:0] push_id;
	} q_cmd_t;

	typedef struct packed {
		logic            empty;
		logic            full;
		logic [ID_W-1:0] head_id;
	} q_status_t;

	// Duration at one step of a pattern; unknown patterns read as end.
	function automatic logic [DUR_W-1:0] rom_dur(input logic [ID_W-1:0] pat,
			input logic [STEP_W-1:0] idx);
		logic [DUR_W-1:0] d;
		d = DUR_END;
		if (pat < ID_W'(N_PATTERNS))
			d = ROM_SEQ[pat][idx];
		return d;
	endfunction

	function automatic logic [LIM_W-1:0] rom_lim(input logic [ID_W-1:0] pat);
		logic [LIM_W-1:0] l;
		l = NO_INT;
		if (pat < ID_W'(N_PATTERNS))
			l = ROM_INT[pat];
		return l;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/morse_pattern_buzzer_sequencer_unit.sv -----
// Buzzer pattern sequencer: each request word is either a 1 ms tick or a play
// request for one of nine fixed Morse-style patterns, and every word yields one
// response word with the buzzer level, a busy flag and a dropped flag. Words
// are taken one per clock while req_stall is low; a word passes through one
// input register and one result register, and the whole state
// update for a word sits in the single-pass next-state logic between them.
// Requests made while a pattern plays wait in a FIFO of QUEUE_DEPTH entries
// and are dropped (flagged) when it is full. Each duration counts down
// duration << TIME_SHIFT ticks. The response register decouples the sides:
// a new word is taken while a finished response still waits downstream.

`default_nettype none

module morse_pattern_buzzer_sequencer_unit
	import mpbs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4,
	parameter int TIME_SHIFT  = 3
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output      logic req_stall,
	input  wire req_t req,
	output      logic rsp_valid,
	input  wire logic rsp_stall,
	output      rsp_t rsp
);

	req_t       req_s1;
	logic       vld_s1;
	rsp_t       rsp_q;
	logic       rsp_valid_q;
	seq_state_t st_q;
	seq_state_t st_nxt;
	rsp_t       rsp_nxt;
	q_cmd_t     q_cmd;
	q_status_t  q_status;
	logic       adv;
	logic       fire;

	// Advance the input stage whenever the result register is free or draining.
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign fire      = vld_s1 && adv;
	assign req_stall = vld_s1 && !adv;

	// Input register: hold the word until the result stage takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
	end

	// Next-state logic for one word; commits only on fire.
	mpbs_ctrl #(
		.TIME_SHIFT(TIME_SHIFT)
	) u_ctrl (
		.go      (fire),
		.req     (req_s1),
		.st      (st_q),
		.q_status(q_status),
		.st_nxt  (st_nxt),
		.q_cmd   (q_cmd),
		.rsp     (rsp_nxt)
	);

	// Pending play requests, oldest first.
	mpbs_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (q_cmd),
		.status(q_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= st_nxt;
		end
	end

	// Result register: drop the valid once taken, load a new word on fire.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			rsp_q <= rsp_nxt;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/core/mpbs_queue.sv -----
`default_nettype none

module mpbs_queue
	import mpbs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire q_cmd_t    cmd,
	output      q_status_t status
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);

	logic [ID_W-1:0] entry_q [QUEUE_DEPTH];
	logic [IW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [SW-1:0]   tail_sum;
	logic [IW-1:0]   tail;

	// Tail wraps at most once since head and count stay within the depth.
	always_comb begin
		tail_sum = SW'(head_q) + SW'(count_q);
		if (tail_sum >= DEPTH_S)
			tail_sum = tail_sum - DEPTH_S;
		tail = tail_sum[IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			entry_q[tail] <= cmd.push_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.pop)
				head_q <= (head_q == LAST) ? '0 : head_q + 1'b1;
			case ({cmd.push, cmd.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign status.empty   = (count_q == '0);
	assign status.full    = (count_q == CW'(QUEUE_DEPTH));
	assign status.head_id = entry_q[head_q];

endmodule

`default_nettype wire

// ----- rtl/core/mpbs_ctrl.sv -----
`default_nettype none

module mpbs_ctrl
	import mpbs_pkg::*;
#(
	parameter int TIME_SHIFT = 3
) (
	input  wire logic       go,
	input  wire req_t       req,
	input  wire seq_state_t st,
	input  wire q_status_t  q_status,
	output      seq_state_t st_nxt,
	output      q_cmd_t     q_cmd,
	output      rsp_t       rsp
);

	seq_state_t        base;
	logic              do_step;
	logic              drop;
	logic              take_pop;
	logic [DUR_W-1:0]  dur0;
	logic [DUR_W-1:0]  dur;
	logic [TICK_W-1:0] tdec;

	always_comb begin
		base     = st;
		do_step  = 1'b0;
		drop     = 1'b0;
		take_pop = 1'b0;
		dur      = DUR_END;
		tdec     = (st.ticks == '0) ? '0 : st.ticks - 1'b1;
		st_nxt   = st;
		q_cmd    = '0;

		if (req.req_type) begin
			if (req.melody_id < ID_W'(N_PATTERNS)) begin
				if (st.playing) begin
					if (q_status.full)
						drop = 1'b1;
					else
						q_cmd.push = 1'b1;
					q_cmd.push_id = req.melody_id;
				end else begin
					base.playing    = 1'b1;
					base.cur_pat    = req.melody_id;
					base.step_idx   = '0;
					base.next_level = 1'b0;
					do_step         = 1'b1;
				end
			end
		end else if (st.playing) begin
			if (tdec == '0)
				do_step = 1'b1;
			else
				st_nxt.ticks = tdec;
		end

		// One step: pre-empt or finish into the queued head, else play on or stop at the end.
		dur0 = rom_dur(base.cur_pat, base.step_idx);
		dur  = dur0;
		if (do_step) begin
			take_pop = !q_status.empty &&
				(({3'b000, base.step_idx} >= rom_lim(base.cur_pat)) || (dur0 == DUR_END));
			if (take_pop) begin
				base.cur_pat    = q_status.head_id;
				base.step_idx   = '0;
				base.next_level = 1'b0;
				dur             = rom_dur(q_status.head_id, '0);
			end
			st_nxt = base;
			if (dur == DUR_END) begin
				st_nxt.playing = 1'b0;
				st_nxt.ticks   = '0;
			end else begin
				st_nxt.out_level  = base.next_level;
				st_nxt.next_level = ~base.next_level;
				st_nxt.step_idx   = base.step_idx + 1'b1;
				st_nxt.ticks      = TICK_W'({{(TICK_W - DUR_W){1'b0}}, dur} << TIME_SHIFT);
			end
		end

		q_cmd.pop = take_pop;
		if (!go) begin
			st_nxt = st;
			q_cmd  = '0;
		end
	end

	assign rsp.buzzer_level = st_nxt.out_level;
	assign rsp.busy_res     = st_nxt.playing;
	assign rsp.dropped      = drop;

endmodule

`default_nettype wire

// ----- rtl/core/mpbs_checker.sv -----
`default_nettype none

`include "morse_pattern_buzzer_sequencer_unit_defines.svh"

module mpbs_checker
	import mpbs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// A stalled response holds.
	`MPBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
		rsp_valid && $stable(rsp), "response changed while stalled")

	// Only a full result stage pushes back on the request side.
	`MPBS_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall,
		"request stalled with result stage free")

	// A request is only dropped while a pattern plays.
	`MPBS_ASSERT_NOW(a_drop_busy, rsp_valid && rsp.dropped, rsp.busy_res,
		"drop flagged while idle")

	// A request taken now is never stalled in the next cycle unless the result side stalls.
	`MPBS_ASSERT_NEXT(a_req_flow, req_valid && !req_stall && !rsp_stall,
		!req_stall || rsp_stall, "request side stalled without output backpressure")

endmodule

bind morse_pattern_buzzer_sequencer_unit mpbs_checker u_mpbs_checker (.*);

`default_nettype wire
